// ===== rtl/lkp_pkg.sv =====
package lkp_pkg;

    // Command codes as seen on the request channel
    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_SET     = 3'd1,
        CMD_REFRESH = 3'd2,
        CMD_SCAN    = 3'd3,
        CMD_CONTROL = 3'd4
    } t_cmd;

    // Configuration register indexes
    localparam logic REG_DISPLAY_ENABLE = 1'b0;
    localparam logic REG_BRIGHTNESS     = 1'b1;

    localparam int LAST_DIGIT = 15;
    localparam int LAST_GLYPH = 15;

    // Panel command bytes
    localparam logic [7:0] BYTE_DATA_AUTO = 8'h40;
    localparam logic [7:0] BYTE_ADDR_ZERO = 8'hC0;
    localparam logic [7:0] BYTE_CTRL      = 8'h80;
    localparam logic [7:0] BYTE_READ_KEYS = 8'h42;
    localparam logic [7:0] CTRL_ON_BIT    = 8'h08;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Classified request passed from front to back
    typedef struct packed {
        t_cmd       kind;
        logic [3:0] pos;
        logic [7:0] seg;
        logic       din;
    } t_item;

    function automatic logic [7:0] glyph(input logic [3:0] v);
        logic [7:0] g;
        unique case (v)
            4'h0: g = 8'h3F;
            4'h1: g = 8'h06;
            4'h2: g = 8'h5B;
            4'h3: g = 8'h4F;
            4'h4: g = 8'h66;
            4'h5: g = 8'h6D;
            4'h6: g = 8'h7D;
            4'h7: g = 8'h07;
            4'h8: g = 8'h7F;
            4'h9: g = 8'h6F;
            4'hA: g = 8'h77;
            4'hB: g = 8'h7C;
            4'hC: g = 8'h39;
            4'hD: g = 8'h5E;
            4'hE: g = 8'h79;
            default: g = 8'h71;
        endcase
        return g;
    endfunction

endpackage

// ===== rtl/lkp_front.sv =====
module lkp_front (
    input  logic [2:0]         i_command,
    input  logic [3:0]         i_digit_position,
    input  logic signed [7:0]  i_digit_value,
    input  logic               i_data_pin_in,
    output lkp_pkg::t_item     o_item
);

    logic in_range;

    // glyph index must be non-negative and not above the last glyph
    assign in_range = !i_digit_value[7]
                      && (i_digit_value[6:0] <= 7'(lkp_pkg::LAST_GLYPH));

    always_comb begin
        unique case (i_command)
            3'(lkp_pkg::CMD_SET):     o_item.kind = lkp_pkg::CMD_SET;
            3'(lkp_pkg::CMD_REFRESH): o_item.kind = lkp_pkg::CMD_REFRESH;
            3'(lkp_pkg::CMD_SCAN):    o_item.kind = lkp_pkg::CMD_SCAN;
            3'(lkp_pkg::CMD_CONTROL): o_item.kind = lkp_pkg::CMD_CONTROL;
            default:                  o_item.kind = lkp_pkg::CMD_TICK;
        endcase
        o_item.pos = i_digit_position;
        o_item.seg = in_range ? lkp_pkg::glyph(i_digit_value[3:0]) : 8'h00;
        o_item.din = i_data_pin_in;
    end

endmodule

// ===== rtl/lkp_queue.sv =====
module lkp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lkp_pkg::t_item i_item,
    output logic           o_space,
    input  logic           i_pop,
    output lkp_pkg::t_item o_item,
    output logic           o_avail
);

    lkp_pkg::t_item r_mem [lkp_pkg::QUEUE_DEPTH];
    logic [lkp_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [lkp_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [lkp_pkg::QUEUE_AW:0]   r_count;
    logic do_push;
    logic do_pop;

    assign o_space = r_count != (lkp_pkg::QUEUE_AW+1)'(lkp_pkg::QUEUE_DEPTH);
    assign o_avail = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_space;
    assign do_pop  = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/lkp_back.sv =====
module lkp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    input  logic           i_cfg_index,
    input  logic [2:0]     i_cfg_data,
    input  lkp_pkg::t_item i_item,
    input  logic           i_avail,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_strobe_pin,
    output logic           o_clock_pin,
    output logic           o_data_pin_out,
    output logic           o_data_pin_drive,
    output logic           o_busy_res,
    output logic [31:0]    o_key_bits,
    output logic           o_key_bits_valid
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_FRAME, PH_WR_LO, PH_WR_HI, PH_RD_LO, PH_RD_HI, PH_GAP
    } t_phase;

    typedef enum logic [1:0] {
        OP_NONE, OP_REFRESH, OP_SCAN, OP_CONTROL
    } t_op;

    t_phase       r_phase, n_phase;
    t_op          r_op, n_op;
    logic [31:0]  r_shift, n_shift;
    logic [4:0]   r_bit, n_bit;
    logic [4:0]   r_byte, n_byte;
    logic [31:0]  r_key, n_key;
    logic [15:0]  r_store [8];
    logic [15:0]  n_store [8];
    logic         r_enable;
    logic [2:0]   r_bright;

    logic         r_out_valid;
    logic         r_stb, r_clk, r_dout, r_drive, r_busy, r_kvalid;
    logic         n_stb, n_clk, n_dout, n_drive, n_kvalid;

    logic         fire;
    logic [4:0]   byte_nx;
    logic [3:0]   sidx;
    logic [15:0]  srow;

    assign fire  = i_avail && (!r_out_valid || i_ready);
    assign o_pop = fire;

    assign byte_nx = r_byte + 5'd1;
    assign sidx    = 4'(byte_nx - 5'd2);
    assign srow    = r_store[sidx[3:1]];

    always_comb begin
        n_phase  = r_phase;
        n_op     = r_op;
        n_shift  = r_shift;
        n_bit    = r_bit;
        n_byte   = r_byte;
        n_key    = r_key;
        n_store  = r_store;
        n_kvalid = 1'b0;

        unique case (r_phase)
            PH_IDLE: begin
                unique case (i_item.kind)
                    lkp_pkg::CMD_SET: begin
                        if (32'(i_item.pos) <= lkp_pkg::LAST_DIGIT) begin
                            for (int r = 0; r < 8; r++) begin
                                n_store[r][i_item.pos] = i_item.seg[r];
                            end
                        end
                    end
                    lkp_pkg::CMD_REFRESH: begin
                        n_op    = OP_REFRESH;
                        n_shift = 32'(lkp_pkg::BYTE_DATA_AUTO);
                        n_bit   = '0;
                        n_byte  = '0;
                        n_phase = PH_FRAME;
                    end
                    lkp_pkg::CMD_SCAN: begin
                        n_op    = OP_SCAN;
                        n_shift = 32'(lkp_pkg::BYTE_READ_KEYS);
                        n_bit   = '0;
                        n_byte  = '0;
                        n_phase = PH_FRAME;
                    end
                    lkp_pkg::CMD_CONTROL: begin
                        n_op    = OP_CONTROL;
                        n_shift = 32'(lkp_pkg::BYTE_CTRL
                                      | (r_enable ? lkp_pkg::CTRL_ON_BIT : 8'h00)
                                      | {5'd0, r_bright});
                        n_bit   = '0;
                        n_byte  = '0;
                        n_phase = PH_FRAME;
                    end
                    default: ;
                endcase
            end
            PH_FRAME: n_phase = PH_WR_LO;
            PH_WR_LO: n_phase = PH_WR_HI;
            PH_WR_HI: begin
                if (r_bit < 5'd7) begin
                    n_bit   = r_bit + 5'd1;
                    n_phase = PH_WR_LO;
                end else begin
                    n_bit  = '0;
                    n_byte = byte_nx;
                    unique case (r_op)
                        OP_REFRESH: begin
                            if (byte_nx == 5'd1) begin
                                n_phase = PH_GAP;
                            end else if (byte_nx >= 5'd18) begin
                                n_phase = PH_IDLE;
                            end else begin
                                // odd store byte is the upper half of a row
                                n_shift = 32'(sidx[0] ? srow[15:8] : srow[7:0]);
                                n_phase = PH_WR_LO;
                            end
                        end
                        OP_SCAN: begin
                            n_shift = '0;
                            n_phase = PH_RD_LO;
                        end
                        default: n_phase = PH_IDLE;
                    endcase
                end
            end
            PH_RD_LO: begin
                n_shift = r_shift | (32'(i_item.din) << r_bit);
                n_phase = PH_RD_HI;
            end
            PH_RD_HI: begin
                if (r_bit < 5'd31) begin
                    n_bit   = r_bit + 5'd1;
                    n_phase = PH_RD_LO;
                end else begin
                    n_bit    = '0;
                    n_key    = r_shift;
                    n_kvalid = 1'b1;
                    n_phase  = PH_IDLE;
                end
            end
            PH_GAP: begin
                n_shift = 32'(lkp_pkg::BYTE_ADDR_ZERO);
                n_bit   = '0;
                n_phase = PH_FRAME;
            end
            default: n_phase = PH_IDLE;
        endcase

        // pin levels follow the phase just entered
        n_stb   = 1'b1;
        n_clk   = 1'b1;
        n_dout  = 1'b1;
        n_drive = 1'b1;
        unique case (n_phase)
            PH_FRAME: n_stb = 1'b0;
            PH_WR_LO: begin
                n_stb  = 1'b0;
                n_clk  = 1'b0;
                n_dout = n_shift[n_bit[2:0]];
            end
            PH_WR_HI: begin
                n_stb  = 1'b0;
                n_dout = n_shift[n_bit[2:0]];
            end
            PH_RD_LO: begin
                n_stb   = 1'b0;
                n_clk   = 1'b0;
                n_drive = 1'b0;
            end
            PH_RD_HI: begin
                n_stb   = 1'b0;
                n_drive = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_op        <= OP_NONE;
            r_shift     <= '0;
            r_bit       <= '0;
            r_byte      <= '0;
            r_key       <= '0;
            r_store     <= '{default: '0};
            r_enable    <= 1'b1;
            r_bright    <= 3'd7;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == lkp_pkg::REG_DISPLAY_ENABLE) begin
                    r_enable <= i_cfg_data[0];
                end else begin
                    r_bright <= i_cfg_data;
                end
            end
            if (fire) begin
                r_phase     <= n_phase;
                r_op        <= n_op;
                r_shift     <= n_shift;
                r_bit       <= n_bit;
                r_byte      <= n_byte;
                r_key       <= n_key;
                r_store     <= n_store;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_stb    <= n_stb;
            r_clk    <= n_clk;
            r_dout   <= n_dout;
            r_drive  <= n_drive;
            r_busy   <= n_phase != PH_IDLE;
            r_kvalid <= n_kvalid;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_strobe_pin     = r_stb;
    assign o_clock_pin      = r_clk;
    assign o_data_pin_out   = r_dout;
    assign o_data_pin_drive = r_drive;
    assign o_busy_res       = r_busy;
    assign o_key_bits       = r_key;
    assign o_key_bits_valid = r_kvalid;

endmodule

// ===== rtl/led_key_panel_serial_host.sv =====
// Host for a three-wire LED and key panel (strobe, clock, shared data pin).
// Every request is one half-bit tick of the serial link and may carry a
// command: set digit, refresh display, scan keys or apply display control.
// Each request yields exactly one response with the pin levels after that
// tick, busy, and the last completed 32-bit key scan.
// Request channel: i_valid/o_ready. Response channel: o_valid/i_ready.
// Config channel: i_cfg_valid/o_cfg_ready with i_cfg_index (0 display
// enable, 1 brightness) and i_cfg_data; always ready, write only while idle.
// A four-entry queue sits between the command decode and the link
// sequencer. The sequencer takes one request per cycle while the response
// register is free or being read, so throughput is one request per clock
// unless i_ready stalls it; a request passes the queue, then the response register.
// When i_ready is low the response register holds, the sequencer stops and
// the queue fills; o_ready drops once four requests are waiting.
// Synchronous reset: display store blank, link idle, key bits zero,
// display enabled at brightness 7, no response pending.
module led_key_panel_serial_host (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_command,
    input  logic [3:0]        i_digit_position,
    input  logic signed [7:0] i_digit_value,
    input  logic              i_data_pin_in,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_strobe_pin,
    output logic              o_clock_pin,
    output logic              o_data_pin_out,
    output logic              o_data_pin_drive,
    output logic              o_busy_res,
    output logic [31:0]       o_key_bits,
    output logic              o_key_bits_valid,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [2:0]        i_cfg_data
);

    lkp_pkg::t_item front_item;
    lkp_pkg::t_item queue_item;
    logic           queue_space;
    logic           queue_avail;
    logic           back_pop;

    assign o_ready     = queue_space;
    assign o_cfg_ready = 1'b1;

    lkp_front u_front (
        .i_command        (i_command),
        .i_digit_position (i_digit_position),
        .i_digit_value    (i_digit_value),
        .i_data_pin_in    (i_data_pin_in),
        .o_item           (front_item)
    );

    lkp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_item  (front_item),
        .o_space (queue_space),
        .i_pop   (back_pop),
        .o_item  (queue_item),
        .o_avail (queue_avail)
    );

    lkp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_item           (queue_item),
        .i_avail          (queue_avail),
        .o_pop            (back_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_strobe_pin     (o_strobe_pin),
        .o_clock_pin      (o_clock_pin),
        .o_data_pin_out   (o_data_pin_out),
        .o_data_pin_drive (o_data_pin_drive),
        .o_busy_res       (o_busy_res),
        .o_key_bits       (o_key_bits),
        .o_key_bits_valid (o_key_bits_valid)
    );

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lkp_pkg::*;

    localparam int LIMIT_CYCLES    = 600000;
    localparam int ITEMS_PER_PHASE = 330;
    localparam int MAX_REPORTS     = 100;
    // ticks after a command until the link is back to idle
    localparam int CONTROL_TICKS = 17;
    localparam int SCAN_TICKS    = 81;
    localparam int REFRESH_TICKS = 291;

    localparam logic [2:0] CMD_FIRST_UNUSED = 3'(CMD_CONTROL) + 3'd1;
    localparam logic [2:0] CMD_LAST_UNUSED  = 3'b111;

    typedef enum logic [2:0] {
        LINK_IDLE, LINK_FRAME, LINK_WR_LO, LINK_WR_HI, LINK_RD_LO, LINK_RD_HI, LINK_GAP
    } t_link_phase;

    typedef enum logic [1:0] {
        XFER_NONE, XFER_REFRESH, XFER_SCAN, XFER_CONTROL
    } t_xfer;

    typedef struct packed {
        logic [2:0] cmd;
        logic [3:0] pos;
        logic [7:0] val;
        logic       din;
    } t_req;

    typedef struct packed {
        logic        stb;
        logic        sclk;
        logic        dout;
        logic        drive;
        logic        busy;
        logic [31:0] keys;
        logic        kval;
    } t_pins;

    logic              i_clk            = 1'b0;
    logic              i_rst_n          = 1'b0;
    logic              i_valid          = 1'b0;
    logic              o_ready;
    logic [2:0]        i_command        = '0;
    logic [3:0]        i_digit_position = '0;
    logic signed [7:0] i_digit_value    = '0;
    logic              i_data_pin_in    = 1'b0;
    logic              o_valid;
    logic              i_ready          = 1'b0;
    logic              o_strobe_pin;
    logic              o_clock_pin;
    logic              o_data_pin_out;
    logic              o_data_pin_drive;
    logic              o_busy_res;
    logic [31:0]       o_key_bits;
    logic              o_key_bits_valid;
    logic              i_cfg_valid      = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_index      = 1'b0;
    logic [2:0]        i_cfg_data       = '0;

    led_key_panel_serial_host i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_command        (i_command),
        .i_digit_position (i_digit_position),
        .i_digit_value    (i_digit_value),
        .i_data_pin_in    (i_data_pin_in),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_strobe_pin     (o_strobe_pin),
        .o_clock_pin      (o_clock_pin),
        .o_data_pin_out   (o_data_pin_out),
        .o_data_pin_drive (o_data_pin_drive),
        .o_busy_res       (o_busy_res),
        .o_key_bits       (o_key_bits),
        .o_key_bits_valid (o_key_bits_valid),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Panel model state
    logic [7:0]  glyph_tab [16] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
                                    8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71};
    logic [15:0] seg_rows [8]   = '{default: '0};
    t_link_phase link_ph  = LINK_IDLE;
    t_xfer       link_op  = XFER_NONE;
    logic [31:0] link_word = '0;
    logic [4:0]  bit_cnt  = '0;
    logic [4:0]  byte_cnt = '0;
    logic [31:0] key_reg  = '0;
    logic        cfg_enable = 1'b1;
    logic [2:0]  cfg_bright = 3'd7;

    t_req  req_q [$];
    t_pins pins_q [$];
    t_req  tx_req;
    t_pins want;
    logic  tx_free;
    int    push_cnt = 0;
    int    acc_cnt  = 0;
    int    resp_cnt = 0;
    int    err_cnt  = 0;
    int    cyc_cnt  = 0;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;

    // Advance the link by one half-bit tick and return the pin levels after it
    function automatic t_pins link_step(input t_req rq);
        t_pins p;
        logic [4:0] sidx;
        p = '{stb: 1'b1, sclk: 1'b1, dout: 1'b1, drive: 1'b1, busy: 1'b0, keys: '0, kval: 1'b0};
        case (link_ph)
            LINK_IDLE: begin
                if (rq.cmd == CMD_SET) begin
                    for (int r = 0; r < 8; r++) begin
                        if ($signed(rq.val) >= 0 && $signed(rq.val) <= LAST_GLYPH)
                            seg_rows[r][rq.pos] = glyph_tab[rq.val[3:0]][r];
                        else
                            seg_rows[r][rq.pos] = 1'b0;
                    end
                end else if (rq.cmd == CMD_REFRESH || rq.cmd == CMD_SCAN ||
                             rq.cmd == CMD_CONTROL) begin
                    if (rq.cmd == CMD_REFRESH) begin
                        link_op   = XFER_REFRESH;
                        link_word = {24'b0, BYTE_DATA_AUTO};
                    end else if (rq.cmd == CMD_SCAN) begin
                        link_op   = XFER_SCAN;
                        link_word = {24'b0, BYTE_READ_KEYS};
                    end else begin
                        link_op   = XFER_CONTROL;
                        link_word = {24'b0, BYTE_CTRL | (cfg_enable ? CTRL_ON_BIT : 8'h00) |
                                     {5'b0, cfg_bright}};
                    end
                    bit_cnt  = '0;
                    byte_cnt = '0;
                    link_ph  = LINK_FRAME;
                end
            end
            LINK_FRAME: link_ph = LINK_WR_LO;
            LINK_WR_LO: link_ph = LINK_WR_HI;
            LINK_WR_HI: begin
                if (bit_cnt < 5'd7) begin
                    bit_cnt = bit_cnt + 5'd1;
                    link_ph = LINK_WR_LO;
                end else begin
                    bit_cnt  = '0;
                    byte_cnt = byte_cnt + 5'd1;
                    if (link_op == XFER_REFRESH) begin
                        if (byte_cnt == 5'd1) begin
                            link_ph = LINK_GAP;
                        end else if (byte_cnt >= 5'd18) begin
                            link_ph = LINK_IDLE;
                        end else begin
                            // store bytes go out row by row, low half first
                            sidx      = byte_cnt - 5'd2;
                            link_word = {24'b0, sidx[0] ? seg_rows[sidx[3:1]][15:8]
                                                        : seg_rows[sidx[3:1]][7:0]};
                            link_ph   = LINK_WR_LO;
                        end
                    end else if (link_op == XFER_SCAN) begin
                        link_word = '0;
                        link_ph   = LINK_RD_LO;
                    end else begin
                        link_ph = LINK_IDLE;
                    end
                end
            end
            LINK_RD_LO: begin
                link_word[bit_cnt] = rq.din;
                link_ph = LINK_RD_HI;
            end
            LINK_RD_HI: begin
                if (bit_cnt < 5'd31) begin
                    bit_cnt = bit_cnt + 5'd1;
                    link_ph = LINK_RD_LO;
                end else begin
                    bit_cnt = '0;
                    key_reg = link_word;
                    p.kval  = 1'b1;
                    link_ph = LINK_IDLE;
                end
            end
            LINK_GAP: begin
                link_word = {24'b0, BYTE_ADDR_ZERO};
                bit_cnt   = '0;
                link_ph   = LINK_FRAME;
            end
            default: link_ph = LINK_IDLE;
        endcase

        case (link_ph)
            LINK_FRAME: p.stb = 1'b0;
            LINK_WR_LO: begin
                p.stb  = 1'b0;
                p.sclk = 1'b0;
                p.dout = link_word[bit_cnt[2:0]];
            end
            LINK_WR_HI: begin
                p.stb  = 1'b0;
                p.dout = link_word[bit_cnt[2:0]];
            end
            LINK_RD_LO: begin
                p.stb   = 1'b0;
                p.sclk  = 1'b0;
                p.drive = 1'b0;
            end
            LINK_RD_HI: begin
                p.stb   = 1'b0;
                p.drive = 1'b0;
            end
            default: ;
        endcase
        p.busy = (link_ph != LINK_IDLE);
        p.keys = key_reg;
        return p;
    endfunction

    function automatic void queue_req(input logic [2:0] c, input logic [3:0] pos,
                                      input logic [7:0] val, input logic din);
        t_req r;
        r.cmd = c;
        r.pos = pos;
        r.val = val;
        r.din = din;
        req_q.push_back(r);
        push_cnt++;
    endfunction

    // Plain tick with random pin level; now and then a stray command rides along
    function automatic void queue_tick();
        logic [2:0] c;
        c = CMD_TICK;
        if ($urandom_range(11) == 0)
            c = 3'($urandom);
        queue_req(c, 4'($urandom), 8'($urandom), 1'($urandom));
    endfunction

    // One command followed by roughly enough ticks to finish its transfer.
    // Sometimes the ticks run short so the next command lands while busy.
    function automatic int queue_burst();
        int sel;
        int nominal;
        int gap;
        logic [2:0] c;
        logic [7:0] v;
        sel = $urandom_range(99);
        if (sel < 40) begin
            c = CMD_SET;
            nominal = 1;
        end else if (sel < 60) begin
            c = CMD_SCAN;
            nominal = SCAN_TICKS;
        end else if (sel < 65) begin
            c = CMD_REFRESH;
            nominal = REFRESH_TICKS;
        end else if (sel < 80) begin
            c = CMD_CONTROL;
            nominal = CONTROL_TICKS;
        end else begin
            c = 3'($urandom);
            nominal = 1;
        end
        v = ($urandom_range(3) != 0) ? 8'($urandom_range(LAST_GLYPH)) : 8'($urandom);
        queue_req(c, 4'($urandom), v, 1'($urandom));
        gap = ($urandom_range(4) == 0) ? $urandom_range(nominal) : nominal + $urandom_range(2);
        for (int k = 0; k < gap; k++)
            queue_tick();
        return gap + 1;
    endfunction

    function automatic bit drained();
        return acc_cnt == push_cnt && pins_q.size() == 0;
    endfunction

    // Hold off new requests until every response is back and the link is idle
    task automatic settle();
        while (!drained())
            @(posedge i_clk);
        while (link_ph != LINK_IDLE) begin
            repeat (8) queue_tick();
            while (!drained())
                @(posedge i_clk);
        end
    endtask

    task automatic write_cfg(input logic en, input logic [2:0] lvl);
        i_cfg_index <= REG_DISPLAY_ENABLE;
        i_cfg_data  <= {2'b00, en};
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        cfg_enable = en;
        i_cfg_index <= REG_BRIGHTNESS;
        i_cfg_data  <= lvl;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        cfg_bright = lvl;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic report(input string msg);
        if (err_cnt < MAX_REPORTS)
            $display("mismatch at %0t ns: %s", $time, msg);
        err_cnt++;
    endtask

    // Request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            tx_free = !i_valid;
            if (i_valid && o_ready) begin
                pins_q.push_back(link_step(tx_req));
                acc_cnt++;
                tx_free = 1'b1;
            end
            if (tx_free) begin
                if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    tx_req = req_q.pop_front();
                    i_command        <= tx_req.cmd;
                    i_digit_position <= tx_req.pos;
                    i_digit_value    <= tx_req.val;
                    i_data_pin_in    <= tx_req.din;
                    i_valid          <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (pins_q.size() == 0) begin
                    report("response with no request outstanding");
                end else begin
                    want = pins_q.pop_front();
                    resp_cnt++;
                    if (o_strobe_pin !== want.stb)
                        report($sformatf("resp %0d strobe %b want %b",
                                         resp_cnt, o_strobe_pin, want.stb));
                    if (o_clock_pin !== want.sclk)
                        report($sformatf("resp %0d clock %b want %b",
                                         resp_cnt, o_clock_pin, want.sclk));
                    if (o_data_pin_out !== want.dout)
                        report($sformatf("resp %0d data out %b want %b",
                                         resp_cnt, o_data_pin_out, want.dout));
                    if (o_data_pin_drive !== want.drive)
                        report($sformatf("resp %0d data drive %b want %b",
                                         resp_cnt, o_data_pin_drive, want.drive));
                    if (o_busy_res !== want.busy)
                        report($sformatf("resp %0d busy %b want %b",
                                         resp_cnt, o_busy_res, want.busy));
                    if (o_key_bits !== want.keys)
                        report($sformatf("resp %0d key bits %h want %h",
                                         resp_cnt, o_key_bits, want.keys));
                    if (o_key_bits_valid !== want.kval)
                        report($sformatf("resp %0d key valid %b want %b",
                                         resp_cnt, o_key_bits_valid, want.kval));
                end
            end
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt >= LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int n;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 28;
        recv_idle_pct = 71;

        // display control with reset settings, then with everything at zero
        queue_req(CMD_CONTROL, 4'd0, 8'd0, 1'b0);
        settle();
        write_cfg(1'b0, 3'd0);
        queue_req(CMD_CONTROL, 4'd0, 8'd0, 1'b0);
        settle();

        // glyph extremes and the blanking values
        queue_req(CMD_SET, 4'd0, 8'd0, 1'b0);
        queue_req(CMD_SET, 4'(LAST_DIGIT), 8'(LAST_GLYPH), 1'b1);
        queue_req(CMD_SET, 4'd1, 8'd10, 1'b0);
        queue_req(CMD_SET, 4'd2, 8'd5, 1'b1);
        queue_req(CMD_SET, 4'd7, 8'h80, 1'b0);
        queue_req(CMD_SET, 4'd8, 8'h7F, 1'b1);
        queue_req(CMD_SET, 4'd9, 8'd16, 1'b0);
        queue_req(CMD_SET, 4'd10, 8'hFF, 1'b1);
        // unused command codes do nothing
        queue_req(CMD_FIRST_UNUSED, 4'd3, 8'd3, 1'b0);
        queue_req(CMD_FIRST_UNUSED + 3'd1, 4'd4, 8'd4, 1'b1);
        queue_req(CMD_LAST_UNUSED, 4'd5, 8'd5, 1'b0);
        // refresh, with commands arriving while busy
        queue_req(CMD_REFRESH, 4'd0, 8'd0, 1'b0);
        queue_req(CMD_SET, 4'd0, 8'd3, 1'b1);
        queue_req(CMD_SCAN, 4'd0, 8'd0, 1'b0);
        queue_req(CMD_CONTROL, 4'd0, 8'd0, 1'b1);
        settle();
        queue_req(CMD_SCAN, 4'd0, 8'd0, 1'b1);
        settle();
        queue_req(CMD_REFRESH, 4'd0, 8'd0, 1'b1);
        settle();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 28;
                    recv_idle_pct = 71;
                    write_cfg(1'b1, 3'd3);
                end
                1: begin
                    send_idle_pct = 71;
                    recv_idle_pct = 28;
                    write_cfg(1'b0, 3'd5);
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    write_cfg(1'b1, 3'd7);
                end
            endcase
            n = 0;
            while (n < ITEMS_PER_PHASE)
                n += queue_burst();
            settle();
        end

        repeat (20) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lkp_pkg.sv
rtl/lkp_front.sv
rtl/lkp_queue.sv
rtl/lkp_back.sv
rtl/led_key_panel_serial_host.sv
sim/tb_top.sv
